### src/mtva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtva_pkg
// Shared types and constants of the MIDI track event voice allocator.
// ----------------------------------------------------------------------------
package mtva_pkg;

  localparam int unsigned Voices      = 20;
  localparam int unsigned VoiceW      = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int unsigned NoteAddrW   = 11;
  localparam int unsigned NoteDepth   = 1 << NoteAddrW;
  localparam int unsigned ClrCntW     = NoteAddrW + 1;
  localparam int unsigned LenW        = 28;
  localparam int unsigned TempoW      = 24;

  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 88;
  localparam int unsigned OutUserW    = 3;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;

  // tdata layout of a result beat, lowest bit first
  localparam int unsigned OffDelta    = 0;
  localparam int unsigned OffChannel  = 28;
  localparam int unsigned OffNote     = 32;
  localparam int unsigned OffVelocity = 39;
  localparam int unsigned OffVoice    = 46;
  localparam int unsigned OffTempo    = 51;
  localparam int unsigned OffVolume   = 75;

  localparam logic [7:0] StMeta       = 8'hFF;
  localparam logic [7:0] StSysex      = 8'hF0;
  localparam logic [7:0] StSysexEsc   = 8'hF7;
  localparam logic [7:0] MetaEnd      = 8'h2F;
  localparam logic [7:0] MetaTempo    = 8'h51;
  localparam logic [6:0] CtrlVolume   = 7'h07;
  localparam logic [3:0] TypeNoteOff  = 4'h8;
  localparam logic [3:0] TypeNoteOn   = 4'h9;
  localparam logic [3:0] TypeCtrl     = 4'hB;
  localparam logic [3:0] TypeProgram  = 4'hC;
  localparam logic [3:0] TypeTouch    = 4'hD;
  localparam logic [3:0] TypeSystem   = 4'hF;

  localparam logic [CfgAddrW-1:0] AddrChanEnable = '0;

  typedef enum logic [2:0] {
    KIND_DELAY   = 3'd0,
    KIND_START   = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_NOFREE  = 3'd3,
    KIND_TEMPO   = 3'd4,
    KIND_END     = 3'd5,
    KIND_VOLUME  = 3'd6,
    KIND_INVALID = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_META_TYPE = 4'd2,
    PH_META_LEN  = 4'd3,
    PH_SYSEX_LEN = 4'd4,
    PH_SKIP      = 4'd5,
    PH_TEMPO     = 4'd6,
    PH_DATA1     = 4'd7,
    PH_DATA2     = 4'd8
  } phase_e;

endpackage
`default_nettype wire

### src/midi_track_event_voice_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_voice_allocator
// Track byte parser with running status, meta and sysex handling, and a
// note-to-voice allocator backed by a note memory.
// ----------------------------------------------------------------------------
// One track byte is taken per beat. For a byte that yields a result, the
// parser state updates and the note memory is read on the accepting edge;
// the resolve stage then resolves the voice against the busy flags, writes
// the note memory back on a start and loads the output register when it is
// free, holding s_axis_tready low meanwhile. A clearing pass after reset
// zeroes the note memory; s_axis_tready stays low, config writes are taken.
// ----------------------------------------------------------------------------
module midi_track_event_voice_allocator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mtva_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [mtva_pkg::CfgDataW-1:0]  pwdata,
  output logic      [mtva_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [mtva_pkg::InDataW-1:0]   s_axis_tdata,  // track_byte
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // delta_ticks, channel, note, velocity, voice, tempo_us, volume, zero pad
  output logic      [mtva_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic      [mtva_pkg::OutUserW-1:0]  m_axis_tuser   // kind
);
  import mtva_pkg::*;

  // configuration
  logic [15:0] chan_en_q;

  // parser state
  phase_e            phase_q, phase_d;
  logic [7:0]        rs_q, rs_d;
  logic [7:0]        meta_q, meta_d;
  logic [LenW-1:0]   acc_q, acc_d;
  logic [LenW-1:0]   skip_q, skip_d;
  logic [6:0]        fd_q, fd_d;
  logic [TempoW-1:0] tempo_q, tempo_d;
  logic              stopped_q, stopped_d;

  // parser result
  logic              res_valid;
  kind_e             res_kind;
  logic [LenW-1:0]   res_delta;
  logic [3:0]        res_ch;
  logic [6:0]        res_note;
  logic [6:0]        res_vel;
  logic [TempoW-1:0] res_tempo;
  logic [6:0]        res_vol;

  // resolve stage
  logic              s2_valid_q;
  kind_e             s2_kind_q;
  logic [LenW-1:0]   s2_delta_q;
  logic [3:0]        s2_ch_q;
  logic [6:0]        s2_note_q;
  logic [6:0]        s2_vel_q;
  logic [TempoW-1:0] s2_tempo_q;
  logic [6:0]        s2_vol_q;

  // voices and note memory
  logic [Voices-1:0]    busy_q;
  logic [VoiceW-1:0]    note_mem [NoteDepth];
  logic [VoiceW-1:0]    rd_q;
  logic [ClrCntW-1:0]   clr_cnt_q;
  logic                 clr_done;
  logic                 mem_we;
  logic [NoteAddrW-1:0] mem_wa;
  logic [VoiceW-1:0]    mem_wd;

  // output register
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  kind_e                out_kind_q;

  logic                 in_acc;
  logic                 commit;
  logic                 free_found;
  logic [VoiceW-1:0]    free_idx;
  kind_e                fin_kind;
  logic [VoiceW-1:0]    fin_voice;
  logic [6:0]           fin_vel;
  logic                 rel_ok;

  assign clr_done      = clr_cnt_q[ClrCntW-1];
  assign s_axis_tready = clr_done && !s2_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign commit        = s2_valid_q && (!out_valid_q || m_axis_tready);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrW-1] == AddrChanEnable[CfgAddrW-1]) ?
                  {16'd0, chan_en_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_en_q <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CfgAddrW-1] == AddrChanEnable[CfgAddrW-1]) begin
      chan_en_q <= pwdata[15:0];
    end
  end

  // parser next state and result
  always_comb begin
    logic [7:0]      b;
    logic [7:0]      rs;
    logic [LenW-1:0] acc_base;
    logic [LenW-1:0] acc_nx;
    logic [LenW-1:0] skip_dec;
    logic            last;
    logic            run;
    phase_e          ph;

    b         = s_axis_tdata;
    phase_d   = phase_q;
    rs_d      = rs_q;
    meta_d    = meta_q;
    acc_d     = acc_q;
    skip_d    = skip_q;
    fd_d      = fd_q;
    tempo_d   = tempo_q;
    stopped_d = stopped_q;
    res_valid = 1'b0;
    res_kind  = KIND_DELAY;
    res_delta = '0;
    res_ch    = '0;
    res_note  = '0;
    res_vel   = '0;
    res_tempo = '0;
    res_vol   = '0;

    last     = !b[7];
    rs       = rs_q;
    ph       = phase_q;
    run      = 1'b1;
    acc_base = acc_q;
    skip_dec = skip_q - LenW'(1);

    if (phase_q == PH_STATUS) begin
      rs       = b[7] ? b : rs_q;
      rs_d     = rs;
      acc_d    = '0;
      acc_base = '0;
      if (rs == StMeta) begin
        ph = PH_META_TYPE;
      end else if (rs == StSysex || rs == StSysexEsc) begin
        ph = PH_SYSEX_LEN;
      end else if (!rs[7] || rs[7:4] == TypeSystem) begin
        stopped_d = 1'b1;
        res_valid = 1'b1;
        res_kind  = KIND_INVALID;
      end else begin
        ph = PH_DATA1;
      end
      phase_d = ph;
      run     = !b[7] && (ph != PH_STATUS);
    end

    acc_nx = {acc_base[LenW-8:0], b[6:0]};

    if (run) begin
      case (ph)
        PH_DELTA: begin
          acc_d = acc_nx;
          if (last) begin
            phase_d = PH_STATUS;
            acc_d   = '0;
            if (acc_nx != '0) begin
              res_valid = 1'b1;
              res_kind  = KIND_DELAY;
              res_delta = acc_nx;
            end
          end
        end
        PH_META_TYPE: begin
          meta_d  = b;
          acc_d   = '0;
          phase_d = PH_META_LEN;
        end
        PH_META_LEN: begin
          acc_d = acc_nx;
          if (last) begin
            acc_d = '0;
            if (meta_q == MetaTempo && acc_nx == LenW'(3)) begin
              tempo_d = '0;
              skip_d  = LenW'(3);
              phase_d = PH_TEMPO;
            end else begin
              skip_d  = acc_nx;
              phase_d = (acc_nx != '0) ? PH_SKIP : PH_DELTA;
              if (meta_q == MetaEnd) begin
                res_valid = 1'b1;
                res_kind  = KIND_END;
              end
            end
          end
        end
        PH_SYSEX_LEN: begin
          acc_d = acc_nx;
          if (last) begin
            acc_d   = '0;
            skip_d  = acc_nx;
            phase_d = (acc_nx != '0) ? PH_SKIP : PH_DELTA;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PH_DELTA;
          end
        end
        PH_TEMPO: begin
          tempo_d = {tempo_q[TempoW-9:0], b};
          skip_d  = skip_dec;
          if (skip_dec == '0) begin
            phase_d   = PH_DELTA;
            res_valid = 1'b1;
            res_kind  = KIND_TEMPO;
            res_tempo = {tempo_q[TempoW-9:0], b};
          end
        end
        PH_DATA1: begin
          fd_d = b[6:0];
          if (rs[7:4] == TypeProgram || rs[7:4] == TypeTouch) begin
            phase_d = PH_DELTA;
          end else begin
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          phase_d  = PH_DELTA;
          res_ch   = rs[3:0];
          res_note = fd_q;
          if (rs[7:4] == TypeNoteOff) begin
            res_valid = 1'b1;
            res_kind  = KIND_RELEASE;
          end else if (rs[7:4] == TypeNoteOn) begin
            if (chan_en_q[rs[3:0]]) begin
              res_valid = 1'b1;
              if (b[6:0] == 7'd0) begin
                res_kind = KIND_RELEASE;
              end else begin
                res_kind = KIND_START;
                res_vel  = b[6:0];
              end
            end
          end else if (rs[7:4] == TypeCtrl && fd_q == CtrlVolume) begin
            res_valid = 1'b1;
            res_kind  = KIND_VOLUME;
            res_note  = '0;
            res_vol   = b[6:0];
          end
        end
        default: begin
          phase_d = PH_DELTA;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DELTA;
      rs_q      <= '0;
      meta_q    <= '0;
      acc_q     <= '0;
      skip_q    <= '0;
      fd_q      <= '0;
      tempo_q   <= '0;
      stopped_q <= 1'b0;
    end else if (in_acc && !stopped_q) begin
      phase_q   <= phase_d;
      rs_q      <= rs_d;
      meta_q    <= meta_d;
      acc_q     <= acc_d;
      skip_q    <= skip_d;
      fd_q      <= fd_d;
      tempo_q   <= tempo_d;
      stopped_q <= stopped_d;
    end
  end

  // resolve stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_acc && !stopped_q && res_valid) begin
      s2_valid_q <= 1'b1;
    end else if (commit) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_kind_q  <= res_kind;
      s2_delta_q <= res_delta;
      s2_ch_q    <= res_ch;
      s2_note_q  <= res_note;
      s2_vel_q   <= res_vel;
      s2_tempo_q <= res_tempo;
      s2_vol_q   <= res_vol;
    end
  end

  // lowest idle voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Voices - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = VoiceW'(i);
      end
    end
  end

  assign rel_ok = {1'b0, rd_q} < (VoiceW + 1)'(Voices);

  always_comb begin
    fin_kind  = s2_kind_q;
    fin_voice = '0;
    fin_vel   = '0;
    case (s2_kind_q)
      KIND_START: begin
        if (free_found) begin
          fin_voice = free_idx;
          fin_vel   = s2_vel_q;
        end else begin
          fin_kind  = KIND_NOFREE;
        end
      end
      KIND_RELEASE: begin
        fin_voice = rd_q;
      end
      default: begin
        fin_voice = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (commit) begin
      if (fin_kind == KIND_START) begin
        busy_q[free_idx] <= 1'b1;
      end else if (fin_kind == KIND_RELEASE && rel_ok) begin
        busy_q[rd_q] <= 1'b0;
      end
    end
  end

  // note memory: clearing pass, write back on start, read on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (!clr_done) begin
      clr_cnt_q <= clr_cnt_q + ClrCntW'(1);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {s2_ch_q, s2_note_q};
    mem_wd = free_idx;
    if (!clr_done) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q[NoteAddrW-1:0];
      mem_wd = '0;
    end else if (commit && fin_kind == KIND_START) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      note_mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      rd_q <= note_mem[{rs_q[3:0], fd_q}];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_kind_q <= fin_kind;
      out_data_q <= {6'd0, s2_vol_q, s2_tempo_q, 5'(fin_voice), fin_vel,
                     s2_note_q, s2_ch_q, s2_delta_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule
`default_nettype wire

### src/mtva_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtva_checker
// Port-level checks of the MIDI track event voice allocator.
// ----------------------------------------------------------------------------
module mtva_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  // delta_ticks, channel, note, velocity, voice, tempo_us, volume, zero pad
  input wire logic [mtva_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic [mtva_pkg::OutUserW-1:0]  m_axis_tuser   // kind
);
  import mtva_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_delay_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DELAY |->
      m_axis_tdata[OffDelta +: 28] != 28'd0)
    else $error("zero delay reported");

  a_voice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_START || m_axis_tuser == KIND_RELEASE) |->
      m_axis_tdata[OffVoice +: 5] < 5'(Voices))
    else $error("voice index out of range");

  a_nofree_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_NOFREE |->
      m_axis_tdata[OffVoice +: 5] == 5'd0 && m_axis_tdata[OffVelocity +: 7] == 7'd0)
    else $error("no-free-voice beat carries a voice");

  a_stop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_INVALID |=> !m_axis_tvalid)
    else $error("result after invalid status");

endmodule

bind midi_track_event_voice_allocator mtva_checker u_mtva_checker (.*);
`default_nettype wire
